@@ design/bol_pkg.sv @@
// ----------------------------------------------------------------------------
// bol_pkg
// Shared types, codes and sizes for the bounded ordered list.
// ----------------------------------------------------------------------------
package bol_pkg;

    localparam int BOL_CAPACITY = 16;
    localparam int WORD_W       = 32;
    localparam int REQ_W        = 3;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 5;

    typedef logic signed [WORD_W-1:0] t_word;

    // request types
    localparam logic [REQ_W-1:0] REQ_INS_FRONT  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_INS_BACK   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INS_AFTER  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_INS_BEFORE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DEL_FRONT  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DEL_BACK   = 3'd5;
    localparam logic [REQ_W-1:0] REQ_DEL_KEY    = 3'd6;

    // result status
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    // cell actions
    localparam logic [1:0] CELL_HOLD = 2'd0;
    localparam logic [1:0] CELL_LOAD = 2'd1;
    localparam logic [1:0] CELL_PREV = 2'd2;
    localparam logic [1:0] CELL_NEXT = 2'd3;

    typedef struct packed {
        logic [1:0] act;
        logic       cmp_en;
    } t_cell_ctl;

endpackage

@@ design/bol_cell.sv @@
// ----------------------------------------------------------------------------
// bol_cell
// One list slot: holds an entry, compares it with the key and shifts.
// ----------------------------------------------------------------------------
module bol_cell
    import bol_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_word     i_key,
    input  t_word     i_new_value,
    input  t_word     i_prev,
    input  t_word     i_next,
    output t_word     o_entry,
    output logic      o_match
);

    t_word r_entry;
    t_word n_entry;
    logic  r_match;

    always_comb begin
        unique case (i_ctl.act)
            CELL_LOAD: n_entry = i_new_value;
            CELL_PREV: n_entry = i_prev;
            CELL_NEXT: n_entry = i_next;
            default:   n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_ctl.cmp_en) begin
            r_match <= (r_entry == i_key);
        end
    end

    assign o_entry = r_entry;
    assign o_match = r_match;

endmodule

@@ design/bounded_ordered_list_top.sv @@
// ----------------------------------------------------------------------------
// bounded_ordered_list_top
// Ordered list of up to CAPACITY signed words kept in a row of shift cells.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one request (type, key, value).
// Output channel: o_valid / i_stall carry one result per request: status,
// the entry now at the front (zero when empty) and the entry count.
// A request is taken when i_valid is high and o_stall is low. At that edge
// every cell compares its entry with the key; then, unless a waiting result
// holds it, the first match is picked, the cells shift or load in one step
// and the result is registered, which raises o_valid.
// One request is in flight at a time: o_stall stays high from the edge that
// took it until its shift is done.
// While a result waits under i_stall the block still takes one new request
// and compares it, but holds its shift until the waiting result is taken.
// Reset (i_rst_n low, synchronous) empties the list and drops any pending
// request or result; cell contents are not cleared.
// ----------------------------------------------------------------------------
module bounded_ordered_list_top
    import bol_pkg::*;
#(
    parameter int CAPACITY = BOL_CAPACITY
)(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [REQ_W-1:0]    i_req_type,
    input  t_word               i_match_key,
    input  t_word               i_new_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output t_word               o_front_value,
    output logic [COUNT_W-1:0]  o_entry_count
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic                r_busy;
    logic [REQ_W-1:0]    r_req;
    t_word               r_val;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       n_count;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [STATUS_W-1:0] n_status;

    t_word               entry [CAPACITY];
    logic [CAPACITY-1:0] match_raw;
    logic [CAPACITY-1:0] below_cnt;
    logic [CAPACITY-1:0] match_v;
    logic [CAPACITY-1:0] first_hit;
    logic [CAPACITY-1:0] ahead;
    t_cell_ctl           ctl [CAPACITY];

    logic in_acc;
    logic fire;
    logic any_hit;
    logic is_ins;
    logic is_del;
    logic is_key;
    logic do_op;
    logic full;
    logic empty;

    assign in_acc = i_valid && !o_stall;
    assign fire   = r_busy && (!r_out_valid || !i_stall);
    assign full   = (r_count == CW'(CAPACITY));
    assign empty  = (r_count == '0);

    // first match among occupied cells
    assign match_v   = match_raw & below_cnt;
    assign any_hit   = |match_v;
    assign first_hit = match_v & (~match_v + 1'b1);
    assign ahead     = first_hit - 1'b1;

    always_comb begin
        is_ins = 1'b0;
        is_del = 1'b0;
        is_key = 1'b0;
        case (r_req) inside
            REQ_INS_FRONT, REQ_INS_BACK: is_ins = 1'b1;
            REQ_INS_AFTER, REQ_INS_BEFORE: begin
                is_ins = 1'b1;
                is_key = 1'b1;
            end
            REQ_DEL_FRONT, REQ_DEL_BACK: is_del = 1'b1;
            REQ_DEL_KEY: begin
                is_del = 1'b1;
                is_key = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        if (is_ins && full) begin
            n_status = ST_FULL;
        end else if (is_del && empty) begin
            n_status = ST_EMPTY;
        end else if (is_key && !any_hit) begin
            n_status = ST_NOT_FOUND;
        end else begin
            n_status = ST_OK;
        end
    end

    assign do_op = fire && (n_status == ST_OK) && (is_ins || is_del);

    always_comb begin
        n_count = r_count;
        if (do_op && is_ins) begin
            n_count = r_count + 1'b1;
        end else if (do_op && is_del) begin
            n_count = r_count - 1'b1;
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic lt;
        logic eq;

        assign below_cnt[i] = (CW'(i) < r_count);

        always_comb begin
            lt = 1'b0;
            eq = 1'b0;
            case (r_req)
                REQ_INS_FRONT:  eq = (i == 0);
                REQ_INS_BACK: begin
                    lt = below_cnt[i];
                    eq = (r_count == CW'(i));
                end
                REQ_INS_AFTER: begin
                    lt = ahead[i] | first_hit[i];
                    eq = (i == 0) ? 1'b0 : first_hit[(i == 0) ? 0 : i-1];
                end
                REQ_INS_BEFORE: begin
                    lt = ahead[i];
                    eq = first_hit[i];
                end
                REQ_DEL_FRONT:  lt = 1'b0;
                REQ_DEL_BACK:   lt = (CW'(i + 1) < r_count);
                REQ_DEL_KEY:    lt = ahead[i];
                default: ;
            endcase
        end

        always_comb begin
            ctl[i].cmp_en = in_acc;
            if (!do_op || lt) begin
                ctl[i].act = CELL_HOLD;
            end else if (is_del) begin
                ctl[i].act = CELL_NEXT;
            end else if (eq) begin
                ctl[i].act = CELL_LOAD;
            end else begin
                ctl[i].act = CELL_PREV;
            end
        end

        bol_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (ctl[i]),
            .i_key       (i_match_key),
            .i_new_value (r_val),
            .i_prev      (entry[(i == 0) ? 0 : i-1]),
            .i_next      (entry[(i == CAPACITY-1) ? CAPACITY-1 : i+1]),
            .o_entry     (entry[i]),
            .o_match     (match_raw[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_busy <= 1'b1;
            end else if (fire) begin
                r_busy <= 1'b0;
            end
            r_count <= n_count;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_req <= i_req_type;
            r_val <= i_new_value;
        end
        if (fire) begin
            r_status <= n_status;
        end
    end

    assign o_stall       = r_busy;
    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_front_value = empty ? t_word'(0) : entry[0];
    assign o_entry_count = COUNT_W'(r_count);

endmodule
